// ===== rtl/core/pie_pkg.sv =====
// Shared constants and types of the particle integration step pipeline.
// No dependencies; pulled in by every module of the block.
package pie_pkg;

    // Default value format, signed Q16.16
    localparam int VALUE_WIDTH_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 16;

    // Factors (dt, 1/m, dt^2/2) are unsigned with a fixed 16-bit fraction
    localparam int FACTOR_W    = 32;
    localparam int FACTOR_FRAC = 16;

    // Configuration register widths and reset values
    localparam int TIME_STEP_W = 16;
    localparam int INV_MASS_W  = 32;
    localparam int BOX_SIDE_W  = 31;
    localparam int BOX_FRAC    = 16;
    localparam int HALF_SQ_W   = 2 * TIME_STEP_W - FACTOR_FRAC - 1;

    localparam logic [TIME_STEP_W-1:0] TIME_STEP_RST = 16'd655;
    localparam logic [INV_MASS_W-1:0]  INV_MASS_RST  = 32'd65536;
    localparam logic [BOX_SIDE_W-1:0]  BOX_SIDE_RST  = 31'd655360;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_TIME_STEP = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INV_MASS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BOX_SIDE  = 2'd2;

    // Commands; the two remaining codes both mean half-step with force shift
    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_EULER  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_VERLET = 2'd1;

    // Pipeline shape: two multiply units in series plus three add stages
    localparam int MUL_DEPTH  = 4;
    localparam int PIPE_DEPTH = 2 * MUL_DEPTH + 3;

    // Per-unit control: stage load enables and the dt/2 shift select
    typedef struct packed {
        logic [MUL_DEPTH-1:0] en;
        logic                 half;
    } pie_mul_ctl_t;

    // Pipeline flow status: stage valid bits and stage load enables
    typedef struct packed {
        logic [PIPE_DEPTH:1] valid;
        logic [PIPE_DEPTH:1] en;
    } pie_flow_t;

endpackage

// ===== rtl/core/pie_sat_add.sv =====
// Saturating signed adder, combinational.
// Depends on pie_pkg for the default value width.
module pie_sat_add #(
    parameter int VALUE_WIDTH = pie_pkg::VALUE_WIDTH_DEF
) (
    input  logic signed [VALUE_WIDTH-1:0] a,
    input  logic signed [VALUE_WIDTH-1:0] b,
    output logic signed [VALUE_WIDTH-1:0] sum
);

    localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    logic [VALUE_WIDTH:0] wide;

    // One guard bit; overflow when the two top bits disagree
    assign wide = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};

    always_comb begin
        if (wide[VALUE_WIDTH] != wide[VALUE_WIDTH-1]) begin
            sum = wide[VALUE_WIDTH] ? VAL_MIN : VAL_MAX;
        end else begin
            sum = wide[VALUE_WIDTH-1:0];
        end
    end

endmodule

// ===== rtl/core/pie_mul.sv =====
// Four-stage signed value times unsigned Q.16 factor, truncating toward zero
// and saturating. Depends on pie_pkg (widths, control struct).
module pie_mul #(
    parameter int VALUE_WIDTH = pie_pkg::VALUE_WIDTH_DEF
) (
    input  logic                              aclk,
    input  pie_pkg::pie_mul_ctl_t             ctl,
    input  logic signed [VALUE_WIDTH-1:0]     value,
    input  logic [pie_pkg::FACTOR_W-1:0]      factor,
    output logic signed [VALUE_WIDTH-1:0]     product
);

    import pie_pkg::*;

    localparam int LO_W      = (VALUE_WIDTH > FACTOR_W) ? FACTOR_W : VALUE_WIDTH;
    localparam int LO_PROD_W = LO_W + FACTOR_W;
    localparam int PROD_W    = VALUE_WIDTH + FACTOR_W;

    localparam logic [VALUE_WIDTH-1:0] MAG_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic [VALUE_WIDTH-1:0] MAG_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    logic                     neg1_reg, neg2_reg, neg3_reg;
    logic                     half1_reg, half2_reg;
    logic [VALUE_WIDTH-1:0]   mag1_reg, mag3_reg, mag3_next;
    logic [LO_PROD_W-1:0]     lo2_reg;
    logic [PROD_W-1:0]        prod_sum;
    logic [PROD_W-1:0]        shifted;
    logic signed [VALUE_WIDTH-1:0] product_reg;

    // Stage 1: sign and magnitude (most negative value maps to 2^(W-1))
    always_ff @(posedge aclk) begin
        if (ctl.en[0]) begin
            neg1_reg  <= value[VALUE_WIDTH-1];
            mag1_reg  <= value[VALUE_WIDTH-1] ? -value : value;
            half1_reg <= ctl.half;
        end
    end

    // Stage 2: partial products, one factor-wide slice each
    always_ff @(posedge aclk) begin
        if (ctl.en[1]) begin
            lo2_reg   <= LO_PROD_W'(mag1_reg[LO_W-1:0]) * LO_PROD_W'(factor);
            neg2_reg  <= neg1_reg;
            half2_reg <= half1_reg;
        end
    end

    generate
        if (VALUE_WIDTH > FACTOR_W) begin : g_split
            logic [VALUE_WIDTH-1:0] hi2_reg;
            always_ff @(posedge aclk) begin
                if (ctl.en[1]) begin
                    hi2_reg <= VALUE_WIDTH'(mag1_reg[VALUE_WIDTH-1:FACTOR_W])
                               * VALUE_WIDTH'(factor);
                end
            end
            assign prod_sum = {hi2_reg, {FACTOR_W{1'b0}}} + PROD_W'(lo2_reg);
        end else begin : g_single
            assign prod_sum = PROD_W'(lo2_reg);
        end
    endgenerate

    // Stage 3: combine, drop the fraction, clamp the magnitude
    always_comb begin
        shifted = half2_reg ? (prod_sum >> (FACTOR_FRAC + 1)) : (prod_sum >> FACTOR_FRAC);
        if (|shifted[PROD_W-1:VALUE_WIDTH-1]) begin
            mag3_next = neg2_reg ? MAG_MIN : MAG_MAX;
        end else begin
            mag3_next = shifted[VALUE_WIDTH-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.en[2]) begin
            mag3_reg <= mag3_next;
            neg3_reg <= neg2_reg;
        end
    end

    // Stage 4: restore the sign
    always_ff @(posedge aclk) begin
        if (ctl.en[3]) begin
            product_reg <= neg3_reg ? -$signed(mag3_reg) : $signed(mag3_reg);
        end
    end

    assign product = product_reg;

endmodule

// ===== rtl/core/pie_flow.sv =====
// Valid bits and stage load enables of the integration pipeline; a stage loads
// whenever m_ready is high or it or any stage after it holds a bubble. Depends on pie_pkg.
module pie_flow (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                m_ready,
    output logic                s_ready,
    output pie_pkg::pie_flow_t  flow
);

    import pie_pkg::*;

    localparam logic [PIPE_DEPTH:1] ONES = '1;

    logic [PIPE_DEPTH:1] valid_reg, valid_next;
    logic [PIPE_DEPTH:1] ready;
    logic [PIPE_DEPTH:1] upstream;

    // A stage may load if the sink takes a request or a bubble sits at or after it
    always_comb begin
        for (int k = 1; k <= PIPE_DEPTH; k++) begin
            ready[k] = m_ready || (|(~valid_reg & (ONES << (k - 1))));
        end
    end

    assign upstream   = {valid_reg[PIPE_DEPTH-1:1], s_valid};
    assign valid_next = (ready & upstream) | (~ready & valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready    = ready[1];
    assign flow.valid = valid_reg;
    assign flow.en    = ready;

endmodule

// ===== rtl/core/particle_integration_step.sv =====
// Top level of the particle integration step: config registers, pipeline
// data path and periodic wrap. Depends on pie_pkg, pie_flow, pie_mul, pie_sat_add.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+-------------------------------------------
//  s_       | s_valid / s_ready    | command, position, speed, force_before/now
//  m_       | m_valid / m_ready    | new_position, new_speed, new_force_before/now
//  cfg_     | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// One request per cycle while m_ready is high or a stage holds a bubble; the pipeline is two
// 4-stage multiply units in series (velocity/acceleration products, then the dt scaled terms)
// plus one add stage after each and a final wrap/output stage.
// Reset clears the valid bits and loads the register defaults; the derived
// dt^2/2 and aligned box side are registered and follow a register write in the next cycle.
// Under m_ready low the pipeline keeps accepting until every stage is full.
module particle_integration_step #(
    parameter int VALUE_WIDTH   = pie_pkg::VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = pie_pkg::FRACTION_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pie_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [pie_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [pie_pkg::CMD_W-1:0]           s_command,
    input  logic signed [VALUE_WIDTH-1:0]       s_position,
    input  logic signed [VALUE_WIDTH-1:0]       s_speed,
    input  logic signed [VALUE_WIDTH-1:0]       s_force_before,
    input  logic signed [VALUE_WIDTH-1:0]       s_force_now,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [VALUE_WIDTH-1:0]       m_new_position,
    output logic signed [VALUE_WIDTH-1:0]       m_new_speed,
    output logic signed [VALUE_WIDTH-1:0]       m_new_force_before,
    output logic signed [VALUE_WIDTH-1:0]       m_new_force_now
);

    import pie_pkg::*;

    localparam int ALIGN_SHL  = (FRACTION_BITS >= BOX_FRAC) ? FRACTION_BITS - BOX_FRAC : 0;
    localparam int ALIGN_SHR  = (FRACTION_BITS < BOX_FRAC) ? BOX_FRAC - FRACTION_BITS : 0;
    localparam int SIDE_EXT_W = BOX_SIDE_W + ALIGN_SHL;
    localparam int CMP_W      = (SIDE_EXT_W > VALUE_WIDTH) ? SIDE_EXT_W : VALUE_WIDTH;
    localparam int SQ_W       = 2 * TIME_STEP_W;

    localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [TIME_STEP_W-1:0] time_step_reg;
    logic [INV_MASS_W-1:0]  inv_mass_reg;
    logic [BOX_SIDE_W-1:0]  box_side_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_step_reg <= TIME_STEP_RST;
            inv_mass_reg  <= INV_MASS_RST;
            box_side_reg  <= BOX_SIDE_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_TIME_STEP: time_step_reg <= cfg_data[TIME_STEP_W-1:0];
                REG_INV_MASS:  inv_mass_reg  <= cfg_data[INV_MASS_W-1:0];
                REG_BOX_SIDE:  box_side_reg  <= cfg_data[BOX_SIDE_W-1:0];
                default: ;
            endcase
        end
    end

    // Derived factors: dt^2/2 and the box side in the value format
    logic [SQ_W-1:0]               dt_sq;
    logic [HALF_SQ_W-1:0]          half_sq_reg;
    logic [SIDE_EXT_W-1:0]         side_ext;
    logic [CMP_W-1:0]              side_cmp;
    logic signed [VALUE_WIDTH-1:0] side_reg, side_next;

    assign dt_sq     = SQ_W'(time_step_reg) * SQ_W'(time_step_reg);
    assign side_ext  = (SIDE_EXT_W'(box_side_reg) << ALIGN_SHL) >> ALIGN_SHR;
    assign side_cmp  = CMP_W'(side_ext);
    assign side_next = (side_cmp > CMP_W'(VAL_MAX)) ? VAL_MAX : side_cmp[VALUE_WIDTH-1:0];

    always_ff @(posedge aclk) begin
        half_sq_reg <= dt_sq[SQ_W-1:FACTOR_FRAC+1];
        side_reg    <= side_next;
    end

    // ---------------------------------------------------------------
    // Flow control
    // ---------------------------------------------------------------
    pie_flow_t flow;

    pie_flow u_flow (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .m_ready (m_ready),
        .s_ready (s_ready),
        .flow    (flow)
    );

    // ---------------------------------------------------------------
    // Side pipes carrying operands alongside the multiply units
    // ---------------------------------------------------------------
    logic signed [VALUE_WIDTH-1:0] x_reg   [1:MUL_DEPTH];
    logic signed [VALUE_WIDTH-1:0] v_reg   [1:2*MUL_DEPTH+1];
    logic signed [VALUE_WIDTH-1:0] ofb_reg [1:2*MUL_DEPTH+2];
    logic signed [VALUE_WIDTH-1:0] ofn_reg [1:2*MUL_DEPTH+2];
    logic                          euler_reg [1:2*MUL_DEPTH+1];
    logic                          shift_cmd;

    // Half-step (and the spare code) shifts the forces
    assign shift_cmd = (s_command != CMD_EULER) && (s_command != CMD_VERLET);

    always_ff @(posedge aclk) begin
        if (flow.en[1]) begin
            x_reg[1]     <= s_position;
            v_reg[1]     <= s_speed;
            ofb_reg[1]   <= shift_cmd ? s_force_now : s_force_before;
            ofn_reg[1]   <= shift_cmd ? '0 : s_force_now;
            euler_reg[1] <= (s_command == CMD_EULER);
        end
        for (int k = 2; k <= MUL_DEPTH; k++) begin
            if (flow.en[k]) x_reg[k] <= x_reg[k-1];
        end
        for (int k = 2; k <= 2 * MUL_DEPTH + 1; k++) begin
            if (flow.en[k]) begin
                v_reg[k]     <= v_reg[k-1];
                euler_reg[k] <= euler_reg[k-1];
            end
        end
        for (int k = 2; k <= 2 * MUL_DEPTH + 2; k++) begin
            if (flow.en[k]) begin
                ofb_reg[k] <= ofb_reg[k-1];
                ofn_reg[k] <= ofn_reg[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // First multiply group: v*dt, f_now/m, f_before/m
    // ---------------------------------------------------------------
    pie_mul_ctl_t ctl_a;
    logic signed [VALUE_WIDTH-1:0] vdt_a, acc_now_a, acc_prev_a;

    assign ctl_a.en   = flow.en[MUL_DEPTH:1];
    assign ctl_a.half = 1'b0;

    pie_mul #(.VALUE_WIDTH(VALUE_WIDTH)) u_mul_vdt (
        .aclk    (aclk),
        .ctl     (ctl_a),
        .value   (s_speed),
        .factor  (FACTOR_W'(time_step_reg)),
        .product (vdt_a)
    );

    pie_mul #(.VALUE_WIDTH(VALUE_WIDTH)) u_mul_acc_now (
        .aclk    (aclk),
        .ctl     (ctl_a),
        .value   (s_force_now),
        .factor  (FACTOR_W'(inv_mass_reg)),
        .product (acc_now_a)
    );

    pie_mul #(.VALUE_WIDTH(VALUE_WIDTH)) u_mul_acc_prev (
        .aclk    (aclk),
        .ctl     (ctl_a),
        .value   (s_force_before),
        .factor  (FACTOR_W'(inv_mass_reg)),
        .product (acc_prev_a)
    );

    // ---------------------------------------------------------------
    // First add stage: x + v*dt, a_prev + a_now, velocity multiplicand
    // ---------------------------------------------------------------
    logic signed [VALUE_WIDTH-1:0] nx1_sum, acc_sum;
    logic signed [VALUE_WIDTH-1:0] acc_prev_reg, mv_reg;
    logic signed [VALUE_WIDTH-1:0] nx1_reg [MUL_DEPTH+1:2*MUL_DEPTH+1];

    pie_sat_add #(.VALUE_WIDTH(VALUE_WIDTH)) u_add_nx1 (
        .a   (x_reg[MUL_DEPTH]),
        .b   (vdt_a),
        .sum (nx1_sum)
    );

    pie_sat_add #(.VALUE_WIDTH(VALUE_WIDTH)) u_add_acc (
        .a   (acc_prev_a),
        .b   (acc_now_a),
        .sum (acc_sum)
    );

    always_ff @(posedge aclk) begin
        if (flow.en[MUL_DEPTH+1]) begin
            nx1_reg[MUL_DEPTH+1] <= nx1_sum;
            acc_prev_reg         <= acc_prev_a;
            mv_reg               <= euler_reg[MUL_DEPTH] ? acc_now_a : acc_sum;
        end
        for (int k = MUL_DEPTH + 2; k <= 2 * MUL_DEPTH + 1; k++) begin
            if (flow.en[k]) nx1_reg[k] <= nx1_reg[k-1];
        end
    end

    // ---------------------------------------------------------------
    // Second multiply group: a_prev*dt^2/2, velocity increment
    // ---------------------------------------------------------------
    pie_mul_ctl_t ctl_tx, ctl_dv;
    logic signed [VALUE_WIDTH-1:0] tx_b, dv_b;

    assign ctl_tx.en   = flow.en[2*MUL_DEPTH+1:MUL_DEPTH+2];
    assign ctl_tx.half = 1'b0;
    assign ctl_dv.en   = flow.en[2*MUL_DEPTH+1:MUL_DEPTH+2];
    assign ctl_dv.half = !euler_reg[MUL_DEPTH+1];

    pie_mul #(.VALUE_WIDTH(VALUE_WIDTH)) u_mul_tx (
        .aclk    (aclk),
        .ctl     (ctl_tx),
        .value   (acc_prev_reg),
        .factor  (FACTOR_W'(half_sq_reg)),
        .product (tx_b)
    );

    pie_mul #(.VALUE_WIDTH(VALUE_WIDTH)) u_mul_dv (
        .aclk    (aclk),
        .ctl     (ctl_dv),
        .value   (mv_reg),
        .factor  (FACTOR_W'(time_step_reg)),
        .product (dv_b)
    );

    // ---------------------------------------------------------------
    // Second add stage: position and velocity results
    // ---------------------------------------------------------------
    logic signed [VALUE_WIDTH-1:0] nx2_sum, nv_sum;
    logic signed [VALUE_WIDTH-1:0] nx2_reg, nv_reg;

    pie_sat_add #(.VALUE_WIDTH(VALUE_WIDTH)) u_add_nx2 (
        .a   (nx1_reg[2*MUL_DEPTH+1]),
        .b   (tx_b),
        .sum (nx2_sum)
    );

    pie_sat_add #(.VALUE_WIDTH(VALUE_WIDTH)) u_add_nv (
        .a   (v_reg[2*MUL_DEPTH+1]),
        .b   (dv_b),
        .sum (nv_sum)
    );

    always_ff @(posedge aclk) begin
        if (flow.en[2*MUL_DEPTH+2]) begin
            nx2_reg <= euler_reg[2*MUL_DEPTH+1] ? nx1_reg[2*MUL_DEPTH+1] : nx2_sum;
            nv_reg  <= nv_sum;
        end
    end

    // ---------------------------------------------------------------
    // Periodic wrap and output register (no overflow possible here)
    // ---------------------------------------------------------------
    logic                          at_or_below_zero, at_or_above_side;
    logic signed [VALUE_WIDTH-1:0] wrap_next;
    logic signed [VALUE_WIDTH-1:0] pos_out_reg, speed_out_reg, fb_out_reg, fn_out_reg;

    assign at_or_below_zero = nx2_reg[VALUE_WIDTH-1] || (nx2_reg == '0);
    assign at_or_above_side = (nx2_reg >= side_reg);

    always_comb begin
        if (at_or_below_zero) begin
            wrap_next = nx2_reg + side_reg;
        end else if (at_or_above_side) begin
            wrap_next = nx2_reg - side_reg;
        end else begin
            wrap_next = nx2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (flow.en[PIPE_DEPTH]) begin
            pos_out_reg   <= wrap_next;
            speed_out_reg <= nv_reg;
            fb_out_reg    <= ofb_reg[2*MUL_DEPTH+2];
            fn_out_reg    <= ofn_reg[2*MUL_DEPTH+2];
        end
    end

    assign m_valid            = flow.valid[PIPE_DEPTH];
    assign m_new_position     = pos_out_reg;
    assign m_new_speed        = speed_out_reg;
    assign m_new_force_before = fb_out_reg;
    assign m_new_force_now    = fn_out_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------

    // Back-pressure on the source only when every stage holds a request
    a_full_before_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (&flow.valid))
        else $error("s_ready low while the pipeline has a bubble");

    // Occupancy moves only with the input and output handshakes
    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |->
            ($countones(flow.valid) == $past($countones(flow.valid))
                + int'($past(s_valid && s_ready)) - int'($past(m_valid && m_ready))))
        else $error("pipeline occupancy does not match accepted requests");

endmodule
